### rtl/core/matrix_multiply_4x4_assert.svh
// ----------------------------------------------------------------------------
// matrix_multiply_4x4 assertion macros
// Shared concurrent assertion forms for the matrix multiply RTL.
// ----------------------------------------------------------------------------
`ifndef MATRIX_MULTIPLY_4X4_ASSERT_SVH
`define MATRIX_MULTIPLY_4X4_ASSERT_SVH

// Same-cycle implication, reset masked.
`define MM4_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, reset masked.
`define MM4_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/mm4_pkg.sv
// ----------------------------------------------------------------------------
// mm4_pkg
// Types, opcodes and defaults for the 4x4 fixed-point matrix multiplier.
// ----------------------------------------------------------------------------
package mm4_pkg;

   localparam int DIM_DEFAULT       = 4;
   localparam int FRAC_BITS_DEFAULT = 16;
   localparam int VAL_W             = 32;
   localparam int IDX_W             = 2;
   localparam int OP_W              = 2;

   localparam logic [OP_W-1:0] OP_WRITE_LEFT  = 2'd0;
   localparam logic [OP_W-1:0] OP_WRITE_RIGHT = 2'd1;
   localparam logic [OP_W-1:0] OP_COMPUTE     = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]         opcode;
      logic [IDX_W-1:0]        col;
      logic [IDX_W-1:0]        row;
      logic signed [VAL_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0]        col_res;
      logic [IDX_W-1:0]        row_res;
      logic signed [VAL_W-1:0] product_value;
      logic                    saturated;
      logic                    last;
   } rsp_type;

endpackage

### rtl/core/matrix_multiply_4x4.sv
// ----------------------------------------------------------------------------
// matrix_multiply_4x4
// Signed fixed-point DIM x DIM matrix product over two on-chip element stores.
// ----------------------------------------------------------------------------
// Usage:
//  - Request channel: an item is taken on a clock edge with start high and
//    busy low. Opcode WRITE_LEFT / WRITE_RIGHT stores value at (col,row) of
//    the left or right matrix; busy stays low, so writes can be issued every
//    cycle. Writes with col or row >= DIM and opcode 3 are dropped.
//  - COMPUTE raises busy and streams DIM*DIM result items on rsp_data, each
//    marked by a one-cycle rsp_strobe, column outer and row inner, the final
//    one flagged with last. The receiver cannot hold results off.
//  - Datapath: one shared 32x32 MAC does one term per cycle, so a compute
//    item makes DIM^3 memory reads, each passing through read, multiply,
//    accumulate and saturate stages. A result is shown once all DIM terms of
//    its element are summed. busy drops in the cycle the last result is shown.
//  - Reset: both stores read as zero (per-entry valid bits cleared), busy
//    low, no result pending. No clearing pass is needed.
// ----------------------------------------------------------------------------
module matrix_multiply_4x4 #(
   parameter int DIM       = mm4_pkg::DIM_DEFAULT,
   parameter int FRAC_BITS = mm4_pkg::FRAC_BITS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  mm4_pkg::req_type req_data,
   output logic             rsp_strobe,
   output mm4_pkg::rsp_type rsp_data
);

   localparam int CELLS  = DIM * DIM;
   localparam int DIM_W  = $clog2(DIM);
   localparam int ADDR_W = $clog2(CELLS);
   localparam int VW     = mm4_pkg::VAL_W;
   localparam int IW     = mm4_pkg::IDX_W;
   localparam int PROD_W = 2 * VW;
   localparam int ACC_W  = PROD_W + $clog2(DIM) + 1;

   // control tag that travels alongside each MAC term
   typedef struct packed {
      logic             valid;
      logic             first_k;
      logic             last_k;
      logic             last_elem;
      logic [DIM_W-1:0] col;
      logic [DIM_W-1:0] row;
   } tag_type;

   // -------------------------------------------------------------------------
   // Request decode
   // -------------------------------------------------------------------------
   logic              accept;
   logic              in_range;
   logic              wr_left;
   logic              wr_right;
   logic              go;
   logic [ADDR_W-1:0] wr_addr;

   assign accept   = start && !busy;
   assign in_range = (int'(req_data.col) < DIM) && (int'(req_data.row) < DIM);
   assign wr_left  = accept && in_range && (req_data.opcode == mm4_pkg::OP_WRITE_LEFT);
   assign wr_right = accept && in_range && (req_data.opcode == mm4_pkg::OP_WRITE_RIGHT);
   assign go       = accept && (req_data.opcode == mm4_pkg::OP_COMPUTE);
   assign wr_addr  = ADDR_W'(int'(req_data.col) * DIM + int'(req_data.row));

   // -------------------------------------------------------------------------
   // Sequencer: walks c, r, k and issues one read pair per cycle
   // -------------------------------------------------------------------------
   logic             busy_ff, busy_in;
   logic             issue_ff, issue_in;
   logic [DIM_W-1:0] c_ff, c_in;
   logic [DIM_W-1:0] r_ff, r_in;
   logic [DIM_W-1:0] k_ff, k_in;
   logic             k_max, r_max, c_max;
   tag_type          s0_tag;

   assign k_max = (k_ff == DIM_W'(DIM - 1));
   assign r_max = (r_ff == DIM_W'(DIM - 1));
   assign c_max = (c_ff == DIM_W'(DIM - 1));

   always_comb begin
      issue_in = issue_ff;
      c_in     = c_ff;
      r_in     = r_ff;
      k_in     = k_ff;
      if (go) begin
         issue_in = 1'b1;
         c_in     = '0;
         r_in     = '0;
         k_in     = '0;
      end else if (issue_ff) begin
         if (!k_max) begin
            k_in = k_ff + 1'b1;
         end else begin
            k_in = '0;
            if (!r_max) begin
               r_in = r_ff + 1'b1;
            end else begin
               r_in = '0;
               if (!c_max) begin
                  c_in = c_ff + 1'b1;
               end else begin
                  issue_in = 1'b0;
               end
            end
         end
      end
   end

   always_comb begin
      s0_tag.valid     = issue_ff;
      s0_tag.first_k   = (k_ff == '0);
      s0_tag.last_k    = k_max;
      s0_tag.last_elem = c_max && r_max;
      s0_tag.col       = c_ff;
      s0_tag.row       = r_ff;
   end

   // element (c,r) sits at c*DIM + r; left(k,r) and right(c,k) per term
   logic [ADDR_W-1:0] rd_addr_l;
   logic [ADDR_W-1:0] rd_addr_r;

   assign rd_addr_l = ADDR_W'(int'(k_ff) * DIM + int'(r_ff));
   assign rd_addr_r = ADDR_W'(int'(c_ff) * DIM + int'(k_ff));

   // -------------------------------------------------------------------------
   // Element stores: one write and one registered read per cycle each.
   // Valid bits make unwritten entries read as zero after reset.
   // -------------------------------------------------------------------------
   logic [VW-1:0]    left_mem  [CELLS];
   logic [VW-1:0]    right_mem [CELLS];
   logic [CELLS-1:0] lv_ff;
   logic [CELLS-1:0] rv_ff;
   logic [VW-1:0]    rdl_ff;
   logic [VW-1:0]    rdr_ff;
   logic             rdl_vld_ff;
   logic             rdr_vld_ff;

   always_ff @(posedge clock) begin
      if (wr_left) begin
         left_mem[wr_addr] <= req_data.value;
      end
      rdl_ff <= left_mem[rd_addr_l];
   end

   always_ff @(posedge clock) begin
      if (wr_right) begin
         right_mem[wr_addr] <= req_data.value;
      end
      rdr_ff <= right_mem[rd_addr_r];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lv_ff      <= '0;
         rv_ff      <= '0;
         rdl_vld_ff <= 1'b0;
         rdr_vld_ff <= 1'b0;
      end else begin
         if (wr_left) begin
            lv_ff[wr_addr] <= 1'b1;
         end
         if (wr_right) begin
            rv_ff[wr_addr] <= 1'b1;
         end
         rdl_vld_ff <= lv_ff[rd_addr_l];
         rdr_vld_ff <= rv_ff[rd_addr_r];
      end
   end

   // -------------------------------------------------------------------------
   // Multiply stage
   // -------------------------------------------------------------------------
   tag_type                   s1_tag_ff;
   tag_type                   s2_tag_ff;
   tag_type                   s3_tag_ff;
   logic signed [VW-1:0]      op_l;
   logic signed [VW-1:0]      op_r;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;

   assign op_l    = rdl_vld_ff ? $signed(rdl_ff) : '0;
   assign op_r    = rdr_vld_ff ? $signed(rdr_ff) : '0;
   assign prod_in = op_l * op_r;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   // -------------------------------------------------------------------------
   // Accumulate stage: full-width exact sum over k
   // -------------------------------------------------------------------------
   logic signed [ACC_W-1:0] acc_ff, acc_in;

   assign acc_in = s2_tag_ff.first_k ? ACC_W'(prod_ff)
                                     : acc_ff + ACC_W'(prod_ff);

   always_ff @(posedge clock) begin
      if (s2_tag_ff.valid) begin
         acc_ff <= acc_in;
      end
   end

   // -------------------------------------------------------------------------
   // Scale and saturate: arithmetic shift by FRAC_BITS, clip to 32 bits
   // -------------------------------------------------------------------------
   logic signed [ACC_W-1:0] scaled;
   logic                    sat_pos;
   logic                    sat_neg;
   logic                    emit;
   mm4_pkg::rsp_type        rsp_in;
   mm4_pkg::rsp_type        rsp_ff;
   logic                    rsp_strobe_ff;

   assign scaled  = acc_ff >>> FRAC_BITS;
   assign sat_pos = !scaled[ACC_W-1] && (|scaled[ACC_W-2:VW-1]);
   assign sat_neg = scaled[ACC_W-1] && !(&scaled[ACC_W-2:VW-1]);
   assign emit    = s3_tag_ff.valid && s3_tag_ff.last_k;

   always_comb begin
      rsp_in.col_res   = IW'(s3_tag_ff.col);
      rsp_in.row_res   = IW'(s3_tag_ff.row);
      rsp_in.saturated = sat_pos || sat_neg;
      rsp_in.last      = s3_tag_ff.last_elem;
      if (sat_pos) begin
         rsp_in.product_value = {1'b0, {(VW-1){1'b1}}};
      end else if (sat_neg) begin
         rsp_in.product_value = {1'b1, {(VW-1){1'b0}}};
      end else begin
         rsp_in.product_value = scaled[VW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_ff <= rsp_in;
      end
   end

   // busy drops together with the final result being registered
   assign busy_in = go ? 1'b1 : ((emit && s3_tag_ff.last_elem) ? 1'b0 : busy_ff);

   // -------------------------------------------------------------------------
   // Control registers
   // -------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         issue_ff      <= 1'b0;
         c_ff          <= '0;
         r_ff          <= '0;
         k_ff          <= '0;
         s1_tag_ff     <= '0;
         s2_tag_ff     <= '0;
         s3_tag_ff     <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         busy_ff       <= busy_in;
         issue_ff      <= issue_in;
         c_ff          <= c_in;
         r_ff          <= r_in;
         k_ff          <= k_in;
         s1_tag_ff     <= s0_tag;
         s2_tag_ff     <= s1_tag_ff;
         s3_tag_ff     <= s2_tag_ff;
         rsp_strobe_ff <= emit;
      end
   end

   assign busy       = busy_ff;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   // -------------------------------------------------------------------------
   // Assertions
   // -------------------------------------------------------------------------
`include "matrix_multiply_4x4_assert.svh"

   `MM4_ASSERT_NEXT(a_go_sets_busy, clock, reset, go, busy_ff, "compute item did not raise busy")
   `MM4_ASSERT_IMPL(a_idle_pipe_empty, clock, reset, !busy_ff, !issue_ff && !s1_tag_ff.valid && !s2_tag_ff.valid && !s3_tag_ff.valid, "MAC pipeline active while idle")
   `MM4_ASSERT_NEXT(a_strobe_spaced, clock, reset, rsp_strobe_ff, !rsp_strobe_ff, "results closer than one per element")
   `MM4_ASSERT_IMPL(a_last_ends_busy, clock, reset, rsp_strobe_ff && rsp_ff.last, !busy_ff, "busy still high on final result")

endmodule
